FILE: src/assert_macros.svh
// assertion macros shared by the checker files
// depends on nothing; each macro reports a failure by $error
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge, reset included
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

// property checked only while the active-low reset is released
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`endif

FILE: src/ucfb_pkg.sv
// shared types, constants and frame byte tables for the config frame builder
// depends on nothing; imported by every module of the block
package ucfb_pkg;

    // command codes
    localparam logic [1:0] OP_PORT = 2'd0;
    localparam logic [1:0] OP_RATE = 2'd1;
    localparam logic [1:0] OP_MSG  = 2'd2;

    // frame constants
    localparam logic [7:0] SYNC1      = 8'hB5;
    localparam logic [7:0] SYNC2      = 8'h62;
    localparam logic [7:0] CLASS_CFG  = 8'h06;
    localparam logic [7:0] ID_PORT    = 8'h00;
    localparam logic [7:0] ID_RATE    = 8'h08;
    localparam logic [7:0] ID_MSG     = 8'h01;
    localparam logic [7:0] LEN_PORT_P = 8'h14;
    localparam logic [7:0] LEN_RATE_P = 8'h06;
    localparam logic [7:0] LEN_MSG_P  = 8'h08;
    localparam logic [7:0] MODE_LO    = 8'hD0;
    localparam logic [7:0] MODE_HI    = 8'h08;
    localparam logic [7:0] ONE_B      = 8'h01;
    localparam logic [7:0] ZERO_B     = 8'h00;

    // byte index within a frame
    localparam int IDX_W = 5;
    localparam logic [IDX_W-1:0] LAST_PORT = IDX_W'(27);
    localparam logic [IDX_W-1:0] LAST_RATE = IDX_W'(13);
    localparam logic [IDX_W-1:0] LAST_MSG  = IDX_W'(15);
    localparam logic [IDX_W-1:0] CK_START  = IDX_W'(2);

    // period divider: 1000 / rate, one quotient bit per cycle
    localparam int DIV_W     = 10;
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_W-1:0]     DIV_DIVIDEND = DIV_W'(1000);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST     = DIV_CNT_W'(DIV_W - 1);
    localparam int PERIOD_W = 16;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_PORT = 2'd0,
        KIND_RATE = 2'd1,
        KIND_MSG  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] baud_rate;
        logic [7:0]  rate_hz;
        logic [7:0]  message_id;
        logic [7:0]  uart1_rate;
        logic [7:0]  usb_rate;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_out_item;

    // classified command handed from front to back
    typedef struct packed {
        t_kind                kind;
        logic [31:0]          baud_rate;
        logic [PERIOD_W-1:0]  period;
        logic [7:0]           message_id;
        logic [7:0]           uart1_rate;
        logic [7:0]           usb_rate;
    } t_desc;

    // index of the final checksum byte for a frame kind
    function automatic logic [IDX_W-1:0] frame_last_idx(input t_kind kind);
        logic [IDX_W-1:0] res;
        case (kind)
            KIND_PORT: res = LAST_PORT;
            KIND_RATE: res = LAST_RATE;
            KIND_MSG:  res = LAST_MSG;
            default:   res = LAST_PORT;
        endcase
        return res;
    endfunction

    // header and payload byte at an index; checksum bytes come from the back end
    function automatic logic [7:0] frame_byte_at(input t_desc d,
                                                 input logic [IDX_W-1:0] idx);
        logic [7:0] res;
        res = ZERO_B;
        case (idx)
            IDX_W'(0): res = SYNC1;
            IDX_W'(1): res = SYNC2;
            IDX_W'(2): res = CLASS_CFG;
            default:   res = ZERO_B;
        endcase
        case (d.kind)
            KIND_PORT: begin
                case (idx)
                    IDX_W'(3):  res = ID_PORT;
                    IDX_W'(4):  res = LEN_PORT_P;
                    IDX_W'(6):  res = ONE_B;
                    IDX_W'(10): res = MODE_LO;
                    IDX_W'(11): res = MODE_HI;
                    IDX_W'(14): res = d.baud_rate[7:0];
                    IDX_W'(15): res = d.baud_rate[15:8];
                    IDX_W'(16): res = d.baud_rate[23:16];
                    IDX_W'(17): res = d.baud_rate[31:24];
                    IDX_W'(18): res = ONE_B;
                    IDX_W'(20): res = ONE_B;
                    default: ;
                endcase
            end
            KIND_RATE: begin
                case (idx)
                    IDX_W'(3):  res = ID_RATE;
                    IDX_W'(4):  res = LEN_RATE_P;
                    IDX_W'(6):  res = d.period[7:0];
                    IDX_W'(7):  res = d.period[15:8];
                    IDX_W'(8):  res = ONE_B;
                    IDX_W'(10): res = ONE_B;
                    default: ;
                endcase
            end
            KIND_MSG: begin
                case (idx)
                    IDX_W'(3):  res = ID_MSG;
                    IDX_W'(4):  res = LEN_MSG_P;
                    IDX_W'(6):  res = ONE_B;
                    IDX_W'(7):  res = d.message_id;
                    IDX_W'(9):  res = d.uart1_rate;
                    IDX_W'(11): res = d.usb_rate;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return res;
    endfunction

endpackage

FILE: src/ucfb_front.sv
// front end: accepts commands, classifies them, computes the rate period
// depends on ucfb_pkg; pushes descriptors into ucfb_queue
module ucfb_front
    import ucfb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    output logic     o_push,
    output t_desc    o_desc,
    input  logic     i_full
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state               r_state, n_state;
    t_desc                r_desc, n_desc;
    logic [DIV_W-1:0]     r_quot, n_quot;
    logic [7:0]           r_rem, n_rem;
    logic [7:0]           r_divisor, n_divisor;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    logic [8:0] rem_sh;
    logic       ge;

    // one restoring division step
    assign rem_sh = {r_rem, r_quot[DIV_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_divisor});

    // control and datapath next state
    always_comb begin
        n_state   = r_state;
        n_desc    = r_desc;
        n_quot    = r_quot;
        n_rem     = r_rem;
        n_divisor = r_divisor;
        n_cnt     = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_desc.baud_rate  = i_in_item.baud_rate;
                    n_desc.period     = '0;
                    n_desc.message_id = i_in_item.message_id;
                    n_desc.uart1_rate = i_in_item.uart1_rate;
                    n_desc.usb_rate   = i_in_item.usb_rate;
                    case (i_in_item.op)
                        OP_PORT: begin
                            n_desc.kind = KIND_PORT;
                            n_state     = S_PUSH;
                        end
                        OP_RATE: begin
                            n_desc.kind = KIND_RATE;
                            n_divisor   = (i_in_item.rate_hz == 8'd0) ? 8'd1
                                                                      : i_in_item.rate_hz;
                            n_quot      = DIV_DIVIDEND;
                            n_rem       = 8'd0;
                            n_cnt       = '0;
                            n_state     = S_DIV;
                        end
                        OP_MSG: begin
                            n_desc.kind = KIND_MSG;
                            n_state     = S_PUSH;
                        end
                        // undefined command: dropped, no frame
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_DIV: begin
                n_rem  = ge ? 8'(rem_sh - {1'b0, r_divisor}) : rem_sh[7:0];
                n_quot = {r_quot[DIV_W-2:0], ge};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_desc.period = PERIOD_W'(n_quot);
                    n_state       = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_desc    <= n_desc;
        r_quot    <= n_quot;
        r_rem     <= n_rem;
        r_divisor <= n_divisor;
        r_cnt     <= n_cnt;
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_push     = (r_state == S_PUSH);
    assign o_desc     = r_desc;

endmodule

FILE: src/ucfb_queue.sv
// short descriptor queue between front and back ends
// depends on ucfb_pkg for the descriptor type and depth
module ucfb_queue
    import ucfb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_desc o_desc
);

    t_desc             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_desc  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule

FILE: src/ucfb_back.sv
// back end: walks a descriptor byte by byte and appends the fletcher checksum
// depends on ucfb_pkg; pops descriptors from ucfb_queue
module ucfb_back
    import ucfb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_desc     i_desc,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic [IDX_W-1:0] r_idx;
    logic [7:0]       r_ck_a, r_ck_b;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic [IDX_W-1:0] last_idx;
    logic [7:0]       raw_byte;
    logic [7:0]       cur_byte;
    logic [7:0]       sum_a;
    logic             advance;
    logic             in_sum;

    // byte selection for the current index
    always_comb begin
        last_idx = frame_last_idx(i_desc.kind);
        raw_byte = frame_byte_at(i_desc, r_idx);
        if (r_idx == last_idx) begin
            cur_byte = r_ck_b;
        end else if (r_idx == last_idx - 1'b1) begin
            cur_byte = r_ck_a;
        end else begin
            cur_byte = raw_byte;
        end
        in_sum  = (r_idx >= CK_START) && (r_idx < last_idx - 1'b1);
        sum_a   = r_ck_a + raw_byte;
        advance = i_q_valid && (!r_out_valid || !i_out_stall);
    end

    // byte counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_idx       <= (r_idx == last_idx) ? '0 : r_idx + 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // running checksum and output register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item.frame_byte <= cur_byte;
            r_out_item.last_byte  <= (r_idx == last_idx);
            if (r_idx == '0) begin
                r_ck_a <= 8'd0;
                r_ck_b <= 8'd0;
            end else if (in_sum) begin
                r_ck_a <= sum_a;
                r_ck_b <= r_ck_b + sum_a;
            end
        end
    end

    assign o_pop       = advance && (r_idx == last_idx);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: src/ubx_config_frame_builder_unit.sv
// top level of the configuration frame builder
// depends on ucfb_pkg, ucfb_front, ucfb_queue and ucfb_back
//
// Usage: one command item on the input channel (i_in_valid / o_in_stall)
// selects a frame kind: port setup (28 bytes), measurement rate (14 bytes)
// or message enable (16 bytes). The frame leaves on the output channel
// (o_out_valid / i_out_stall) one byte per item, last_byte set on the
// final checksum byte. An undefined op is taken and produces nothing.
// A taken command passes the front state register, the queue and the
// back end output register before its first byte shows; a rate command
// first runs the period divider, one quotient bit per cycle. Throughput:
// the back end sends one byte per cycle while the receiver does not
// stall; the front takes a new command once it has pushed the last one
// while the two-entry queue has room, so the byte stream stays unbroken.
// Reset clears the front state, the queue and the output valid at once.
// While the receiver stalls the current byte holds and the back end
// waits; the front keeps filling the queue until it is full.
module ubx_config_frame_builder_unit
    import ucfb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic  push, full, pop, q_valid;
    t_desc push_desc, head_desc;

    // command intake and classification
    ucfb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_push     (push),
        .o_desc     (push_desc),
        .i_full     (full)
    );

    // decoupling queue
    ucfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_desc  (head_desc)
    );

    // frame serializer
    ucfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_desc      (head_desc),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: src/ucfb_checker.sv
// port-level checks for the configuration frame builder, bound to the top
// depends on ucfb_pkg and assert_macros.svh
`include "assert_macros.svh"

module ucfb_checker
    import ucfb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    logic out_take;
    logic out_wait;
    logic last_take;
    logic next_ok;
    assign out_take  = o_out_valid && !i_out_stall;
    assign out_wait  = o_out_valid && i_out_stall;
    assign last_take = out_take && o_out_item.last_byte;
    assign next_ok   = !o_out_valid || (o_out_item.frame_byte == SYNC1);

    // a stalled byte holds its value
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, out_wait |=> o_out_valid && $stable(o_out_item))

    // reset empties the output side
    `ASSERT_CLK(a_rst_out, i_clk, !i_rst_n |=> !o_out_valid)

    // reset leaves the front ready for a command
    `ASSERT_CLK(a_rst_in, i_clk, !i_rst_n |=> !o_in_stall)

    // a frame that follows a finished one opens with the first sync byte
    `ASSERT_CLK_RST(a_next_sync, i_clk, i_rst_n, last_take |=> next_ok)

endmodule

bind ubx_config_frame_builder_unit ucfb_checker u_ucfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
